// ===== hdl/hcbd_pkg.sv =====
`timescale 1ns / 1ps

package hcbd_pkg;

   // Counter width default and the fixed width of the limit register
   localparam int COUNT_BITS_DEFAULT = 32;
   localparam int CFG_BITS           = 32;

   localparam logic [CFG_BITS-1:0] MAX_BODY_RESET = 32'd1048576;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   typedef enum logic [1:0] {
      KIND_DATA      = 2'd0,
      KIND_COMPLETE  = 2'd1,
      KIND_TOO_LARGE = 2'd2,
      KIND_MALFORMED = 2'd3
   } kind_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   // Decode one ASCII hex character; valid is low for anything else
   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type d;
      d.valid = 1'b1;
      d.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d.value = 4'(c - 8'h37);
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

endpackage

// ===== hdl/hcbd_req_if.sv =====
`timescale 1ns / 1ps

interface hcbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       start_of_body;

   modport source (output valid, output in_byte, output start_of_body, input ready);
   modport sink   (input valid, input in_byte, input start_of_body, output ready);
endinterface

// ===== hdl/hcbd_rsp_if.sv =====
`timescale 1ns / 1ps

interface hcbd_rsp_if;
   logic              valid;
   logic              ready;
   logic [7:0]        out_byte;
   hcbd_pkg::kind_type kind;

   modport source (output valid, output out_byte, output kind, input ready);
   modport sink   (input valid, input out_byte, input kind, output ready);
endinterface

// ===== hdl/http_chunked_body_decoder.sv =====
`timescale 1ns / 1ps

// HTTP/1.1 chunked body decoder. Raw body bytes enter on req_if, one beat per
// byte; start_of_body on a beat clears all decoder state before that byte is
// handled. Each hex size line ended by CR LF either starts a chunk whose bytes
// leave on rsp_if as payload beats (kind DATA), or ends the body with a single
// status beat: COMPLETE for a zero size, TOO_LARGE when the chunk would push the
// body total past csr max_body_bytes, MALFORMED for a bad or overflowing size
// line. The CR LF after each chunk is dropped unchecked, and after a status
// beat every byte is ignored until the next start_of_body. The block takes one
// byte per clock: a byte sits in an input register, and the state update and the
// limit add/compare run on it and load the result register; rsp back-pressure is
// the only thing that slows it. Write csr only while the decoder is idle.
module http_chunked_body_decoder #(
   parameter int COUNT_BITS = hcbd_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   hcbd_req_if.sink                       req_if,
   hcbd_rsp_if.source                     rsp_if,
   input  logic                           csr_wr_en,
   input  logic [hcbd_pkg::CFG_BITS-1:0]  csr_wr_data
);
   import hcbd_pkg::*;

   localparam int SUM_BITS = ((COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS) + 1;

   typedef enum logic [2:0] {
      PH_SIZE_START  = 3'd0,
      PH_SIZE_DIGITS = 3'd1,
      PH_SIZE_BAD    = 3'd2,
      PH_DATA        = 3'd3,
      PH_SKIP2       = 3'd4,
      PH_SKIP1       = 3'd5,
      PH_DONE        = 3'd6
   } phase_type;

   // Registers
   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;
   logic                  in_start_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_byte_ff,  rsp_byte_in;
   kind_type              rsp_kind_ff,  rsp_kind_in;
   logic                  rsp_load;
   phase_type             phase_ff,     phase_in;
   logic [COUNT_BITS-1:0] acc_ff,       acc_in;
   logic                  cr_ff,        cr_in;
   logic [COUNT_BITS-1:0] chunk_ff,     chunk_in;
   logic [COUNT_BITS-1:0] delivered_ff, delivered_in;
   logic [CFG_BITS-1:0]   max_body_ff;

   // Handshake
   logic advance;
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   // Current state after the optional body restart
   phase_type             ph_cur;
   logic [COUNT_BITS-1:0] acc_cur, chunk_cur, delivered_cur;
   logic                  cr_cur;
   hex_digit_type         digit;
   logic [SUM_BITS-1:0]   total;
   logic                  too_large;
   logic [COUNT_BITS-1:0] chunk_dec;
   phase_type             ph_size;

   always_comb begin
      ph_cur        = in_start_ff ? PH_SIZE_START : phase_ff;
      acc_cur       = in_start_ff ? '0 : acc_ff;
      cr_cur        = in_start_ff ? 1'b0 : cr_ff;
      chunk_cur     = in_start_ff ? '0 : chunk_ff;
      delivered_cur = in_start_ff ? '0 : delivered_ff;
      digit         = hex_decode(in_byte_ff);
      total         = SUM_BITS'(acc_cur) + SUM_BITS'(delivered_cur);
      too_large     = total > SUM_BITS'(max_body_ff);
      chunk_dec     = chunk_cur - COUNT_BITS'(1);
   end

   // Per-byte state update and result selection
   always_comb begin
      phase_in     = ph_cur;
      acc_in       = acc_cur;
      cr_in        = cr_cur;
      chunk_in     = chunk_cur;
      delivered_in = delivered_cur;
      rsp_load     = 1'b0;
      rsp_byte_in  = 8'd0;
      rsp_kind_in  = KIND_DATA;
      ph_size      = ph_cur;
      unique case (ph_cur)
         PH_SIZE_START, PH_SIZE_DIGITS, PH_SIZE_BAD: begin
            if (cr_cur && in_byte_ff == CHAR_LF) begin
               // Close the size line
               cr_in    = 1'b0;
               rsp_load = 1'b1;
               priority if (ph_cur != PH_SIZE_DIGITS) begin
                  phase_in    = PH_DONE;
                  rsp_kind_in = KIND_MALFORMED;
               end else if (too_large) begin
                  phase_in    = PH_DONE;
                  rsp_kind_in = KIND_TOO_LARGE;
               end else if (acc_cur == '0) begin
                  phase_in    = PH_DONE;
                  rsp_kind_in = KIND_COMPLETE;
               end else begin
                  rsp_load = 1'b0;
                  chunk_in = acc_cur;
                  acc_in   = '0;
                  phase_in = PH_DATA;
               end
            end else begin
               // A stray CR poisons the line; then handle this byte as size text
               if (cr_cur) begin
                  ph_size = PH_SIZE_BAD;
               end
               cr_in    = 1'b0;
               phase_in = ph_size;
               if (in_byte_ff == CHAR_CR) begin
                  cr_in = 1'b1;
               end else if (!digit.valid || ph_size == PH_SIZE_BAD ||
                            acc_cur[COUNT_BITS-1 -: 4] != 4'd0) begin
                  phase_in = PH_SIZE_BAD;
               end else begin
                  acc_in   = {acc_cur[COUNT_BITS-5:0], digit.value};
                  phase_in = PH_SIZE_DIGITS;
               end
            end
         end
         PH_DATA: begin
            // Forward payload, count down the chunk, saturate the body total
            chunk_in = chunk_dec;
            if (delivered_cur != '1) begin
               delivered_in = delivered_cur + COUNT_BITS'(1);
            end
            if (chunk_dec == '0) begin
               phase_in = PH_SKIP2;
            end
            rsp_load    = 1'b1;
            rsp_byte_in = in_byte_ff;
            rsp_kind_in = KIND_DATA;
         end
         PH_SKIP2: begin
            phase_in = PH_SKIP1;
         end
         PH_SKIP1: begin
            phase_in = PH_SIZE_START;
            acc_in   = '0;
            cr_in    = 1'b0;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (advance && rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // State, input register and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_SIZE_START;
         acc_ff       <= '0;
         cr_ff        <= 1'b0;
         chunk_ff     <= '0;
         delivered_ff <= '0;
         max_body_ff  <= MAX_BODY_RESET;
      end else begin
         if (csr_wr_en) begin
            max_body_ff <= csr_wr_data;
         end
         if (req_if.ready) begin
            in_valid_ff <= req_if.valid;
            in_byte_ff  <= req_if.in_byte;
            in_start_ff <= req_if.start_of_body;
         end
         if (advance) begin
            phase_ff     <= phase_in;
            acc_ff       <= acc_in;
            cr_ff        <= cr_in;
            chunk_ff     <= chunk_in;
            delivered_ff <= delivered_in;
            if (rsp_load) begin
               rsp_byte_ff <= rsp_byte_in;
               rsp_kind_ff <= rsp_kind_in;
            end
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.out_byte = rsp_byte_ff;
   assign rsp_if.kind     = rsp_kind_ff;

   // Checks
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      advance && phase_ff == PH_DONE && !in_start_ff |-> !rsp_load)
      else $error("decoder produced a beat after the body ended");

   a_status_ends_body: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_load && rsp_kind_in != KIND_DATA |=> phase_ff == PH_DONE)
      else $error("status beat did not end the body");

   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> chunk_ff != '0)
      else $error("payload phase with an empty chunk");

   a_status_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff != KIND_DATA |-> rsp_byte_ff == 8'd0)
      else $error("status beat carries a nonzero byte");

endmodule
